FILE: hdl/epsp_pkg.sv
// Package for the encoder period, speed and position core.
// Widths, constants, codes, FSM state type and controller/datapath structs.
// No dependencies.
package epsp_pkg;

    localparam int NUM_ENCODERS_DEF = 2;
    localparam int TIME_BITS        = 32;
    localparam int FRAC_BITS        = 8;

    localparam int TS_W     = TIME_BITS;
    localparam int RES_W    = 16;
    localparam int COUNT_W  = 32;
    localparam int PERIOD_W = 33;
    localparam int SPEED_W  = 25;
    localparam int POS_W    = 48;
    localparam int MAG_W    = 32;

    localparam int KIND_W     = 2;
    localparam int IN_TDATA_W = 40;
    localparam int IN_TUSER_W = 4;
    localparam int OUT_TDATA_W = 144;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_NUM_W = 59;
    localparam int DIV_DEN_W = 48;

    localparam logic [DIV_NUM_W-1:0] SPEED_NUM_Q =
        DIV_NUM_W'(64'd360000000) << FRAC_BITS;
    localparam logic [26:0] PI_OVER_180_Q32 = 27'd74961321;
    localparam logic [26:0] TWO_PI_Q24      = 27'd105414357;
    localparam logic [8:0]  POS_DEG_SCALE   = 9'd360;
    localparam int          RAD_POS_SHIFT   = 24 - FRAC_BITS;

    localparam logic [RES_W-1:0]    RES_RESET    = 16'd1024;
    localparam logic [RES_W-1:0]    LIMIT_RESET  = 16'd600;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 33'd1000000;

    localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPEED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POS   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RES_FIRST  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_SECOND = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIM  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIM   = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FILTER,
        ST_SCALE,
        ST_DONE
    } epsp_state_t;

    typedef struct packed {
        logic capture;
        logic prep;
        logic div_start;
        logic filter;
        logic scale;
        logic load_out;
    } epsp_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              skip;
        logic              div_done;
        logic              out_free;
    } epsp_stat_t;

endpackage

FILE: hdl/encoder_period_speed_position_core.sv
// Top level of the two-encoder period, speed and position core.
// Instantiates epsp_ctrl and epsp_dp; uses epsp_pkg.
//
// Edge items update the selected encoder's period and count; speed and position
// queries return Q8 values in degrees or radians. Speed and position queries use
// the shared restoring divider, which produces one of its 59 quotient bits per
// cycle. A speed query with zero resolution or zero period, or a position query
// with zero resolution, needs no division and skips the divider. A wait on
// m_axis_tready holds a finished item back from the output register. Kind 3 is
// dropped without a result. A new item is taken once the previous one has
// reached the output register, even while that result still waits.
module encoder_period_speed_position_core
    import epsp_pkg::*;
#(
    parameter int NUM_ENCODERS = NUM_ENCODERS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // b_level, timestamp_us
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // kind, encoder_select, unit_select
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // edge_count, signed_period,
                                                  // speed_q8, position_q8
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    epsp_cmd_t  cmd;
    epsp_stat_t stat;

    assign cfg_ready = 1'b1;

    epsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser[KIND_W-1:0]),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    epsp_dp #(
        .NUM_ENCODERS (NUM_ENCODERS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tdata  (s_axis_tdata),
        .in_tuser  (s_axis_tuser),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

FILE: hdl/epsp_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on epsp_pkg for default widths.
module epsp_div
    import epsp_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W:0]    trial;
    logic              ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        step_next = step_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            step_next = STEP_W'(NUM_W);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (step_reg != '0)
        begin
            step_next = step_reg - 1'b1;
            done_next = (step_reg == STEP_W'(1));
            quo_next  = {quo_reg[NUM_W-2:0], ge};
            rem_next  = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

FILE: hdl/epsp_dp.sv
// Datapath: configuration registers, per-encoder state, operand prep,
// speed filter, unit scaling and output register. Uses epsp_pkg, epsp_div.
module epsp_dp
    import epsp_pkg::*;
#(
    parameter int NUM_ENCODERS = NUM_ENCODERS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  in_tdata,
    input  logic [IN_TUSER_W-1:0]  in_tuser,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  epsp_cmd_t              cmd,
    output epsp_stat_t             stat,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data
);

    localparam int ENC_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
    localparam int OUT_PAD_W = OUT_TDATA_W - (COUNT_W + PERIOD_W + SPEED_W + POS_W);
    localparam logic [DIV_NUM_W-1:0] POS_NEG_MAX = DIV_NUM_W'(1) << (POS_W - 1);
    localparam logic [DIV_NUM_W-1:0] POS_POS_MAX = POS_NEG_MAX - 1'b1;

    logic [RES_W-1:0] res_first_reg, res_second_reg, speed_lim_reg, jump_lim_reg;

    logic [TS_W-1:0]     last_time_reg [NUM_ENCODERS];
    logic [TS_W-1:0]     last_time_next [NUM_ENCODERS];
    logic [PERIOD_W-1:0] period_reg [NUM_ENCODERS];
    logic [PERIOD_W-1:0] period_next [NUM_ENCODERS];
    logic [COUNT_W-1:0]  count_reg [NUM_ENCODERS];
    logic [COUNT_W-1:0]  count_next [NUM_ENCODERS];
    logic [SPEED_W-1:0]  speed_reg [NUM_ENCODERS];
    logic [SPEED_W-1:0]  speed_next [NUM_ENCODERS];

    logic [KIND_W-1:0] kind_reg;
    logic [ENC_W-1:0]  sel_reg;
    logic              fwd_reg, rad_reg;
    logic [TS_W-1:0]   ts_reg;
    logic [RES_W-1:0]  res_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic              neg_reg, skip_reg;
    logic [SPEED_W-1:0] speed_res_reg;
    logic [POS_W-1:0]  pos_res_reg;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [ENC_W-1:0]    sel_in;
    logic [TS_W-1:0]     cur_time;
    logic [PERIOD_W-1:0] cur_period;
    logic [COUNT_W-1:0]  cur_count;
    logic [SPEED_W-1:0]  cur_speed;
    logic [RES_W-1:0]    res_sel;
    logic [TS_W-1:0]     edge_diff;
    logic [PERIOD_W-1:0] edge_period;
    logic [PERIOD_W-1:0] per_abs;
    logic [COUNT_W-1:0]  cnt_abs;

    logic [DIV_DEN_W-1:0] speed_den, div_den;
    logic [DIV_NUM_W-1:0] rad_prod, div_num, div_quo;
    logic [DIV_NUM_W-1:0] div_quo_w;
    logic [40:0]          deg_prod;
    logic                 div_done;

    logic                 q_ok, jump_ok, speed_ok;
    logic [SPEED_W-1:0]   cand;
    logic [SPEED_W:0]     sdiff, sdiff_abs;

    logic [SPEED_W-1:0]   s_abs, rad_speed;
    logic [51:0]          rprod;
    logic [DIV_NUM_W-1:0] p_raw, p_val;
    logic [POS_W-1:0]     pos_mag;

    // Item capture
    assign sel_in = (int'(in_tuser[2]) >= NUM_ENCODERS) ? ENC_W'(NUM_ENCODERS - 1)
                                                        : ENC_W'(in_tuser[2]);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= in_tuser[1:0];
            sel_reg  <= sel_in;
            rad_reg  <= in_tuser[3];
            fwd_reg  <= in_tdata[0];
            ts_reg   <= in_tdata[TS_W:1];
        end
    end

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_first_reg  <= RES_RESET;
            res_second_reg <= RES_RESET;
            speed_lim_reg  <= LIMIT_RESET;
            jump_lim_reg   <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RES_FIRST:  res_first_reg  <= cfg_data;
                CFG_RES_SECOND: res_second_reg <= cfg_data;
                CFG_SPEED_LIM:  speed_lim_reg  <= cfg_data;
                CFG_JUMP_LIM:   jump_lim_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Selected encoder state
    assign cur_time   = last_time_reg[sel_reg];
    assign cur_period = period_reg[sel_reg];
    assign cur_count  = count_reg[sel_reg];
    assign cur_speed  = speed_reg[sel_reg];
    assign res_sel    = (sel_reg == '0) ? res_first_reg : res_second_reg;

    assign edge_diff   = ts_reg - cur_time;
    assign edge_period = fwd_reg ? {1'b0, edge_diff} : PERIOD_W'(0) - {1'b0, edge_diff};
    assign per_abs     = cur_period[PERIOD_W-1] ? PERIOD_W'(0) - cur_period : cur_period;
    assign cnt_abs     = cur_count[COUNT_W-1] ? COUNT_W'(0) - cur_count : cur_count;

    // Speed filter
    assign div_quo  = div_quo_w;
    assign q_ok     = div_quo <= DIV_NUM_W'({speed_lim_reg, {FRAC_BITS{1'b0}}});
    assign cand     = neg_reg ? SPEED_W'(0) - {1'b0, div_quo[SPEED_W-2:0]}
                              : {1'b0, div_quo[SPEED_W-2:0]};
    assign sdiff    = {cand[SPEED_W-1], cand} - {cur_speed[SPEED_W-1], cur_speed};
    assign sdiff_abs = sdiff[SPEED_W] ? (SPEED_W+1)'(0) - sdiff : sdiff;
    assign jump_ok  = sdiff_abs <= (SPEED_W+1)'({jump_lim_reg, {FRAC_BITS{1'b0}}});
    assign speed_ok = !skip_reg && q_ok && jump_ok;

    always_comb
    begin
        last_time_next = last_time_reg;
        period_next    = period_reg;
        count_next     = count_reg;
        speed_next     = speed_reg;
        if (cmd.prep && kind_reg == KIND_EDGE)
        begin
            last_time_next[sel_reg] = ts_reg;
            period_next[sel_reg]    = edge_period;
            count_next[sel_reg]     = fwd_reg ? cur_count + 1'b1 : cur_count - 1'b1;
        end
        if (cmd.filter && speed_ok)
        begin
            speed_next[sel_reg] = cand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENCODERS; i++)
            begin
                last_time_reg[i] <= '0;
                period_reg[i]    <= PERIOD_RESET;
                count_reg[i]     <= '0;
                speed_reg[i]     <= '0;
            end
        end
        else
        begin
            last_time_reg <= last_time_next;
            period_reg    <= period_next;
            count_reg     <= count_next;
            speed_reg     <= speed_next;
        end
    end

    // Operand prep
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            res_reg <= res_sel;
            if (kind_reg == KIND_SPEED)
            begin
                mag_reg  <= per_abs[MAG_W-1:0];
                neg_reg  <= cur_period[PERIOD_W-1];
                skip_reg <= (res_sel == '0) || (cur_period == '0);
            end
            else
            begin
                mag_reg  <= cnt_abs;
                neg_reg  <= cur_count[COUNT_W-1];
                skip_reg <= (res_sel == '0);
            end
        end
    end

    assign speed_den = res_reg * mag_reg;
    assign deg_prod  = mag_reg * POS_DEG_SCALE;
    assign rad_prod  = mag_reg * TWO_PI_Q24;
    assign div_den   = (kind_reg == KIND_SPEED) ? speed_den : DIV_DEN_W'(res_reg);
    assign div_num   = (kind_reg == KIND_SPEED) ? SPEED_NUM_Q :
                       rad_reg ? rad_prod : DIV_NUM_W'({deg_prod, {FRAC_BITS{1'b0}}});

    epsp_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo_w),
        .done  (div_done)
    );

    // Unit scaling and saturation
    assign s_abs     = cur_speed[SPEED_W-1] ? SPEED_W'(0) - cur_speed : cur_speed;
    assign rprod     = s_abs * PI_OVER_180_Q32;
    assign rad_speed = cur_speed[SPEED_W-1] ? SPEED_W'(0) - SPEED_W'(rprod[51:32])
                                            : SPEED_W'(rprod[51:32]);

    assign p_raw = rad_reg ? (div_quo >> RAD_POS_SHIFT) : div_quo;
    assign p_val = skip_reg ? '0 : p_raw;

    always_comb
    begin
        if (neg_reg)
            pos_mag = (p_val > POS_NEG_MAX) ? POS_W'(POS_NEG_MAX) : POS_W'(p_val);
        else
            pos_mag = (p_val > POS_POS_MAX) ? POS_W'(POS_POS_MAX) : POS_W'(p_val);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            speed_res_reg <= rad_reg ? rad_speed : cur_speed;
            pos_res_reg   <= neg_reg ? POS_W'(0) - pos_mag : pos_mag;
        end
    end

    // Output register
    assign out_valid_next = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}},
                             (kind_reg == KIND_POS)   ? pos_res_reg   : POS_W'(0),
                             (kind_reg == KIND_SPEED) ? speed_res_reg : SPEED_W'(0),
                             cur_period,
                             cur_count};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign stat.kind     = kind_reg;
    assign stat.skip     = skip_reg;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

FILE: hdl/epsp_ctrl.sv
// Controller FSM: sequences capture, prep, divide, filter, scale, output.
// Uses epsp_pkg state, command and status types.
module epsp_ctrl
    import epsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [KIND_W-1:0] in_kind,
    output logic              in_ready,
    input  epsp_stat_t        stat,
    output epsp_cmd_t         cmd
);

    epsp_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid && in_kind != KIND_NONE)
                    state_next = ST_PREP;
            ST_PREP:
                state_next = (stat.kind == KIND_EDGE) ? ST_DONE : ST_MUL;
            ST_MUL:
                if (!stat.skip)
                    state_next = ST_DIV;
                else
                    state_next = (stat.kind == KIND_SPEED) ? ST_FILTER : ST_SCALE;
            ST_DIV:
                if (stat.div_done)
                    state_next = (stat.kind == KIND_SPEED) ? ST_FILTER : ST_SCALE;
            ST_FILTER:
                state_next = ST_SCALE;
            ST_SCALE:
                state_next = ST_DONE;
            ST_DONE:
                if (stat.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_PREP:   cmd.prep = 1'b1;
            ST_MUL:    cmd.div_start = !stat.skip;
            ST_FILTER: cmd.filter = 1'b1;
            ST_SCALE:  cmd.scale = 1'b1;
            ST_DONE:   cmd.load_out = stat.out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> state_reg == ST_DIV)
        else $error("divider done outside divide state");

    a_ignore_none: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && in_kind == KIND_NONE) |=> state_reg == ST_IDLE)
        else $error("unknown kind started work");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !stat.out_free) |=> state_reg == ST_DONE)
        else $error("result dropped while output busy");

endmodule

FILE: verif/epsp_result_checker.sv
// Result checker for encoder_period_speed_position_core.
// Snoops the input, result and register-write transfers, predicts every result
// and compares it field by field. Depends on epsp_pkg only.
module epsp_result_checker
    import epsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     outstanding,
    output int                     results_checked
);

    localparam longint unsigned SPEED_SCALED = 64'd360000000 << FRAC_BITS;
    localparam longint unsigned DEG2RAD_Q32  = 64'd74961321;
    localparam longint unsigned TURN_RAD_Q24 = 64'd105414357;
    localparam int              RAD_SHIFT    = 24 - FRAC_BITS;

    typedef struct packed {
        logic [COUNT_W-1:0]  edge_count;
        logic [PERIOD_W-1:0] signed_period;
        logic [SPEED_W-1:0]  speed_q8;
        logic [POS_W-1:0]    position_q8;
    } enc_result_t;

    // per-encoder state
    logic [TS_W-1:0]    last_stamp [2];
    longint             period_us  [2];
    logic [COUNT_W-1:0] edge_total [2];
    longint             speed_hist [2];

    logic [RES_W-1:0]   res_cfg [2];
    logic [15:0]        speed_lim;
    logic [15:0]        jump_lim;

    enc_result_t        pending_results [$];
    int                 mismatch_total;
    int                 checked_total;

    function automatic longint clamp_signed(longint unsigned mag, bit neg, int bits);
        longint unsigned lim;
        lim = (64'd1 << (bits - 1)) - 64'd1;
        if (neg)
        begin
            if (mag > lim + 64'd1)
                mag = lim + 64'd1;
            return -longint'(mag);
        end
        if (mag > lim)
            mag = lim;
        return longint'(mag);
    endfunction

    function automatic bit predict_encoder_item(input logic [KIND_W-1:0] kind,
                                                input logic sel, input logic b_level,
                                                input logic [TS_W-1:0] stamp,
                                                input logic unit_sel,
                                                output enc_result_t r);
        int              e;
        longint unsigned res;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned dm;
        longint unsigned lim_q;
        longint          p;
        longint          cand;
        longint          d;
        longint          s;
        longint          speed_out;
        longint          pos_out;
        logic [TS_W-1:0] diff;
        bit              neg;
        e = sel;
        res = res_cfg[e];
        speed_out = 0;
        pos_out = 0;
        r = '0;
        if (kind == KIND_NONE)
            return 1'b0;
        case (kind)
            KIND_EDGE:
            begin
                diff = stamp - last_stamp[e];
                period_us[e] = b_level ? longint'(diff) : -longint'(diff);
                last_stamp[e] = stamp;
                edge_total[e] = b_level ? edge_total[e] + 1 : edge_total[e] - 1;
            end
            KIND_SPEED:
            begin
                p = period_us[e];
                if (res != 0 && p != 0)
                begin
                    neg = p < 0;
                    mag = neg ? -p : p;
                    q = SPEED_SCALED / (res * mag);
                    lim_q = longint'(speed_lim) << FRAC_BITS;
                    if (q <= lim_q)
                    begin
                        cand = neg ? -longint'(q) : longint'(q);
                        d = cand - speed_hist[e];
                        dm = (d < 0) ? -d : d;
                        lim_q = longint'(jump_lim) << FRAC_BITS;
                        if (dm <= lim_q)
                            speed_hist[e] = clamp_signed(q, neg, SPEED_W);
                    end
                end
                if (unit_sel)
                begin
                    s = speed_hist[e];
                    neg = s < 0;
                    mag = neg ? -s : s;
                    q = (mag * DEG2RAD_Q32) >> 32;
                    speed_out = neg ? -longint'(q) : longint'(q);
                end
                else
                    speed_out = speed_hist[e];
            end
            default:
            begin
                s = longint'($signed(edge_total[e]));
                neg = s < 0;
                mag = neg ? -s : s;
                q = 0;
                if (res != 0)
                begin
                    if (unit_sel)
                        q = ((mag * TURN_RAD_Q24) / res) >> RAD_SHIFT;
                    else
                        q = ((mag * 64'd360) << FRAC_BITS) / res;
                end
                pos_out = clamp_signed(q, neg, POS_W);
            end
        endcase
        r.edge_count    = edge_total[e];
        r.signed_period = period_us[e][PERIOD_W-1:0];
        r.speed_q8      = speed_out[SPEED_W-1:0];
        r.position_q8   = pos_out[POS_W-1:0];
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : snoop
        enc_result_t got;
        enc_result_t want;
        enc_result_t pred;
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                last_stamp[i] = '0;
                period_us[i]  = 1000000;
                edge_total[i] = '0;
                speed_hist[i] = 0;
                res_cfg[i]    = 16'd1024;
            end
            speed_lim = 16'd600;
            jump_lim  = 16'd600;
            pending_results.delete();
            mismatch_total = 0;
            checked_total  = 0;
            mismatches      <= 0;
            outstanding     <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RES_FIRST:  res_cfg[0] = cfg_data;
                    CFG_RES_SECOND: res_cfg[1] = cfg_data;
                    CFG_SPEED_LIM:  speed_lim  = cfg_data;
                    CFG_JUMP_LIM:   jump_lim   = cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.edge_count    = m_axis_tdata[31:0];
                got.signed_period = m_axis_tdata[64:32];
                got.speed_q8      = m_axis_tdata[89:65];
                got.position_q8   = m_axis_tdata[137:90];
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no result expected: %h", m_axis_tdata);
                    mismatch_total++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    checked_total++;
                    if (got.edge_count !== want.edge_count)
                    begin
                        $error("edge_count: expected %0d, actual %0d",
                               $signed(want.edge_count), $signed(got.edge_count));
                        mismatch_total++;
                    end
                    if (got.signed_period !== want.signed_period)
                    begin
                        $error("signed_period: expected %0d, actual %0d",
                               $signed(want.signed_period), $signed(got.signed_period));
                        mismatch_total++;
                    end
                    if (got.speed_q8 !== want.speed_q8)
                    begin
                        $error("speed_q8: expected %0d, actual %0d",
                               $signed(want.speed_q8), $signed(got.speed_q8));
                        mismatch_total++;
                    end
                    if (got.position_q8 !== want.position_q8)
                    begin
                        $error("position_q8: expected %0d, actual %0d",
                               $signed(want.position_q8), $signed(got.position_q8));
                        mismatch_total++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (predict_encoder_item(s_axis_tuser[1:0], s_axis_tuser[2],
                                         s_axis_tdata[0], s_axis_tdata[32:1],
                                         s_axis_tuser[3], pred))
                    pending_results.push_back(pred);
            end
            mismatches      <= mismatch_total;
            outstanding     <= pending_results.size();
            results_checked <= checked_total;
        end
    end

endmodule

FILE: verif/encoder_period_speed_position_core_test.sv
// Testbench top for encoder_period_speed_position_core.
// Drives edge, query and register-write transfers with random idling on both
// sides; epsp_result_checker does the prediction. Uses epsp_pkg.
module encoder_period_speed_position_core_test;
    import epsp_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // b_level, timestamp_us
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // kind, encoder_select, unit_select
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // edge_count, signed_period,
                                                 // speed_q8, position_q8
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int  mismatches;
    int  outstanding;
    int  results_checked;

    logic        stalls_on = 1'b0;
    int          stall_left;
    logic [31:0] stim_stamp [2] = '{32'd0, 32'd0};
    logic        stim_dir   [2] = '{1'b1, 1'b0};
    int          n_edges, n_speed, n_pos, n_ignored, n_writes;

    always #5 clk = ~clk;

    encoder_period_speed_position_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    epsp_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stalls_on && $urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= pick_gap();
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic sel,
                             input logic b_level, input logic [31:0] stamp,
                             input logic unit_sel);
        int gap;
        s_axis_tdata  <= IN_TDATA_W'({stamp, b_level});
        s_axis_tuser  <= {unit_sel, sel, kind};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        case (kind)
            KIND_EDGE:
            begin
                n_edges++;
                stim_stamp[sel] = stamp;
            end
            KIND_SPEED: n_speed++;
            KIND_POS:   n_pos++;
            default:    n_ignored++;
        endcase
        gap = stalls_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_writes++;
        @(posedge clk);
    endtask

    // wait until every expected result is out, then idle before returning
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic program_block(input logic [15:0] res0, input logic [15:0] res1,
                                 input logic [15:0] spd, input logic [15:0] jmp);
        drain_block();
        write_reg(CFG_RES_FIRST, res0);
        write_reg(CFG_RES_SECOND, res1);
        write_reg(CFG_SPEED_LIM, spd);
        write_reg(CFG_JUMP_LIM, jmp);
    endtask

    task automatic random_item();
        int          r;
        logic [1:0]  kind;
        logic        sel;
        logic        b_level;
        logic [31:0] delta;
        logic [31:0] stamp;
        r = $urandom_range(0, 99);
        kind = (r < 50) ? KIND_EDGE : (r < 75) ? KIND_SPEED : (r < 95) ? KIND_POS : KIND_NONE;
        sel = 1'($urandom_range(0, 1));
        b_level = 1'($urandom_range(0, 1));
        stamp = $urandom();
        if (kind == KIND_EDGE)
        begin
            if ($urandom_range(0, 7) == 0)
                stim_dir[sel] = ~stim_dir[sel];
            b_level = stim_dir[sel];
            r = $urandom_range(0, 99);
            if (r < 40)
                delta = $urandom_range(586, 20000);
            else if (r < 70)
                delta = $urandom_range(20000, 2000000);
            else if (r < 85)
                delta = $urandom_range(0, 600);
            else
                delta = $urandom();
            // occasionally an edge at an unrelated time
            if (!(r >= 85 && $urandom_range(0, 1) == 1))
                stamp = stim_stamp[sel] + delta;
        end
        if ($urandom_range(0, 39) == 0)
            stalls_on <= ~stalls_on;
        send_item(kind, sel, b_level, stamp, 1'($urandom_range(0, 1)));
    endtask

    task automatic random_items(input int target);
        int start;
        start = n_edges + n_speed + n_pos;
        while (n_edges + n_speed + n_pos - start < target)
            random_item();
    endtask

    task automatic directed_items();
        send_item(KIND_SPEED, 1'b0, 1'b1, 32'd0, 1'b0);          // reset period
        send_item(KIND_SPEED, 1'b0, 1'b0, 32'hFFFFFFFF, 1'b1);
        send_item(KIND_POS,   1'b0, 1'b1, 32'd0, 1'b0);          // zero count
        send_item(KIND_EDGE,  1'b0, 1'b1, 32'd0, 1'b0);          // zero period
        send_item(KIND_SPEED, 1'b0, 1'b1, 32'd0, 1'b0);
        send_item(KIND_EDGE,  1'b0, 1'b0, 32'hFFFFFFFF, 1'b1);   // widest period
        send_item(KIND_SPEED, 1'b0, 1'b0, 32'd0, 1'b0);
        send_item(KIND_EDGE,  1'b0, 1'b1, 32'd5, 1'b0);          // timestamp wrap
        send_item(KIND_SPEED, 1'b0, 1'b1, 32'd0, 1'b1);          // over speed limit
        send_item(KIND_NONE,  1'b1, 1'b1, 32'hFFFFFFFF, 1'b1);   // dropped
        send_item(KIND_EDGE,  1'b1, 1'b0, 32'd1000, 1'b0);
        send_item(KIND_SPEED, 1'b1, 1'b0, 32'd0, 1'b0);          // reverse speed
        send_item(KIND_SPEED, 1'b1, 1'b1, 32'd0, 1'b1);
        send_item(KIND_POS,   1'b1, 1'b0, 32'd0, 1'b0);          // negative count
        send_item(KIND_POS,   1'b1, 1'b1, 32'd0, 1'b1);
        send_item(KIND_EDGE,  1'b1, 1'b0, 32'd1300, 1'b0);
        send_item(KIND_SPEED, 1'b1, 1'b0, 32'd0, 1'b0);
        send_item(KIND_EDGE,  1'b1, 1'b1, 32'd3300, 1'b0);       // direction flip
        send_item(KIND_SPEED, 1'b1, 1'b1, 32'd0, 1'b1);
        send_item(KIND_SPEED, 1'b1, 1'b0, 32'd0, 1'b0);
        send_item(KIND_EDGE,  1'b1, 1'b1, 32'd3300, 1'b1);       // zero period
        send_item(KIND_SPEED, 1'b1, 1'b1, 32'd0, 1'b0);
        send_item(KIND_POS,   1'b0, 1'b0, 32'hFFFFFFFF, 1'b1);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        stalls_on <= 1'b1;
        random_items(80);
        program_block(16'd1, 16'd1, 16'hFFFF, 16'hFFFF);
        random_items(85);
        program_block(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        random_items(80);
        program_block(16'd0, 16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)));
        random_items(80);
        program_block(16'($urandom_range(100, 4000)), 16'($urandom_range(100, 4000)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        random_items(110);
        program_block(16'd1024, 16'd1, 16'hFFFF, 16'd600);
        random_items(90);
        drain_block();
        $display("Covered %0d edges, %0d speed and %0d position queries, %0d dropped items,",
                 n_edges, n_speed, n_pos, n_ignored);
        $display("%0d register writes over six settings; %0d results checked",
                 n_writes, results_checked);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
hdl/epsp_pkg.sv
hdl/epsp_div.sv
hdl/epsp_dp.sv
hdl/epsp_ctrl.sv
hdl/encoder_period_speed_position_core.sv
verif/epsp_result_checker.sv
verif/encoder_period_speed_position_core_test.sv
